/* rtl/one_wire_bus_master_unit_defines.svh */
// assertion helpers for the one-wire master checker
`ifndef ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH
`define ONE_WIRE_BUS_MASTER_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, quiet in reset
`define OWBM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, clocked on clk, quiet in reset
`define OWBM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/owbm_pkg.sv */
`default_nettype none

package owbm_pkg;

	// timing defaults and sizes
	localparam int BITS_PER_BYTE_DEF = 8;
	localparam int TIMER_WIDTH_DEF   = 10;
	localparam int QUEUE_DEPTH       = 2;
	localparam int CFG_DATA_W        = 10;
	localparam int CFG_INDEX_W       = 3;

	// register widths
	localparam int W_RESET_LOW  = 10;
	localparam int W_PRES_DLY   = 8;
	localparam int W_RESET_REC  = 10;
	localparam int W_SLOT       = 8;
	localparam int W_W1_LOW     = 4;
	localparam int W_W0_LOW     = 7;
	localparam int W_RD_LOW     = 4;
	localparam int W_RD_SAMPLE  = 6;

	// opcodes
	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_RESET      = 3'd1;
	localparam logic [2:0] OP_WRITE_BYTE = 3'd2;
	localparam logic [2:0] OP_READ_BYTE  = 3'd3;
	localparam logic [2:0] OP_WRITE_BIT  = 3'd4;
	localparam logic [2:0] OP_READ_BIT   = 3'd5;

	// register indexes
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_RESET_LOW   = 3'd0,
		REG_PRES_DELAY  = 3'd1,
		REG_RESET_REC   = 3'd2,
		REG_SLOT        = 3'd3,
		REG_W1_LOW      = 3'd4,
		REG_W0_LOW      = 3'd5,
		REG_RD_LOW      = 3'd6,
		REG_RD_SAMPLE   = 3'd7
	} owbm_reg_t;

	// sequencer phases
	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_RST_LOW  = 3'd1,
		PH_RST_WAIT = 3'd2,
		PH_RST_REC  = 3'd3,
		PH_SLOT     = 3'd4
	} owbm_phase_t;

	typedef struct packed {
		logic [2:0] opcode;
		logic [7:0] data_byte;
		logic       line_level;
	} owbm_in_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic       presence_found;
		logic [7:0] read_value;
		logic       command_rejected;
	} owbm_out_t;

	// classified request held in the queue
	typedef struct packed {
		logic       cmd;
		logic [2:0] op;
		logic [7:0] load_data;
		logic       line;
	} owbm_entry_t;

	typedef struct packed {
		logic [W_RESET_LOW-1:0] reset_low_time;
		logic [W_PRES_DLY-1:0]  presence_sample_delay;
		logic [W_RESET_REC-1:0] reset_recovery_time;
		logic [W_SLOT-1:0]      slot_time;
		logic [W_W1_LOW-1:0]    write_one_low_time;
		logic [W_W0_LOW-1:0]    write_zero_low_time;
		logic [W_RD_LOW-1:0]    read_low_time;
		logic [W_RD_SAMPLE-1:0] read_sample_time;
	} owbm_cfg_t;

	localparam owbm_cfg_t CFG_RESET = '{
		reset_low_time:        10'd500,
		presence_sample_delay: 8'd50,
		reset_recovery_time:   10'd450,
		slot_time:             8'd70,
		write_one_low_time:    4'd6,
		write_zero_low_time:   7'd60,
		read_low_time:         4'd6,
		read_sample_time:      6'd15
	};

endpackage

`default_nettype wire

/* rtl/owbm_front.sv */
`default_nettype none

module owbm_front
	import owbm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire owbm_in_t    in_item,
	output logic             entry_valid,
	output owbm_entry_t      entry,
	input  wire logic        entry_pop
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

	owbm_entry_t      mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	owbm_entry_t      cls;
	logic             push;

	// classify the request: command or plain tick, and the data to load
	always_comb begin
		cls.op   = in_item.opcode;
		cls.line = in_item.line_level;
		unique case (in_item.opcode) inside
			OP_RESET, OP_READ_BYTE, OP_READ_BIT: begin
				cls.cmd       = 1'b1;
				cls.load_data = 8'd0;
			end
			OP_WRITE_BYTE: begin
				cls.cmd       = 1'b1;
				cls.load_data = in_item.data_byte;
			end
			OP_WRITE_BIT: begin
				cls.cmd       = 1'b1;
				cls.load_data = {7'd0, in_item.data_byte[0]};
			end
			default: begin
				cls.cmd       = 1'b0;
				cls.load_data = 8'd0;
			end
		endcase
	end

	assign in_ready    = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign push        = in_valid && in_ready;
	assign entry_valid = (count_q != '0);
	assign entry       = mem_q[rd_ptr_q];

	// queue storage, depth is a power of two so pointers wrap on their own
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= cls;
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (entry_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !entry_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && entry_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

/* rtl/owbm_back.sv */
`default_nettype none

module owbm_back
	import owbm_pkg::*;
#(
	parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF,
	parameter int TIMER_WIDTH   = TIMER_WIDTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        entry_valid,
	input  wire owbm_entry_t entry,
	output logic             entry_pop,
	input  wire owbm_cfg_t   cfg,
	output logic             out_valid,
	input  wire logic        out_ready,
	output owbm_out_t        out_item
);

	localparam int CW = (TIMER_WIDTH > 10) ? TIMER_WIDTH : 10;
	localparam logic [TIMER_WIDTH-1:0] TMAX   = {TIMER_WIDTH{1'b1}};
	localparam logic [CW-1:0]          TMAX_C = CW'(TMAX);
	localparam logic [3:0]             BYTE_BITS = 4'(BITS_PER_BYTE);

	owbm_phase_t            phase_q, phase_d;
	logic [2:0]             kind_q, kind_d;
	logic [TIMER_WIDTH-1:0] tick_q, tick_d;
	logic [3:0]             bits_q, bits_d;
	logic [7:0]             shift_q, shift_d;
	logic                   pres_q, pres_d;
	logic                   drive_q, drive_d;
	logic                   done, rej;
	owbm_out_t              res;
	owbm_out_t              out_q;
	logic                   out_valid_q;

	function automatic logic clamp_unused_guard(input logic a);
		clamp_unused_guard = a;
	endfunction

	// limit a time to what the tick counter can reach
	function automatic logic [CW-1:0] clamp(input logic [CW-1:0] v);
		clamp = (v > TMAX_C) ? TMAX_C : v;
	endfunction

	function automatic logic is_read(input logic [2:0] k);
		is_read = (k == OP_READ_BYTE) || (k == OP_READ_BIT);
	endfunction

	assign entry_pop = entry_valid && (!out_valid_q || out_ready);

	// one tick of the sequencer
	always_comb begin
		logic [TIMER_WIDTH-1:0] tick_inc;
		logic [CW-1:0]          tick_x;
		logic [CW-1:0]          low;
		logic [CW-1:0]          endv;
		logic [CW-1:0]          sp;
		logic [3:0]             total;
		logic [2:0]             idx;

		phase_d  = phase_q;
		kind_d   = kind_q;
		tick_d   = tick_q;
		bits_d   = bits_q;
		shift_d  = shift_q;
		pres_d   = pres_q;
		drive_d  = drive_q;
		done     = 1'b0;
		rej      = (phase_q != PH_IDLE) && entry.cmd;
		tick_inc = (tick_q == TMAX) ? tick_q : tick_q + 1'b1;
		tick_x   = CW'(tick_inc);
		low      = '0;
		endv     = '0;
		sp       = '0;
		total    = 4'd1;
		idx      = '0;

		unique case (phase_q)
			PH_IDLE: begin
				if (entry.cmd) begin
					kind_d  = entry.op;
					tick_d  = '0;
					drive_d = 1'b1;
					if (entry.op == OP_RESET) begin
						phase_d = PH_RST_LOW;
						pres_d  = 1'b0;
					end else begin
						phase_d = PH_SLOT;
						bits_d  = ((entry.op == OP_WRITE_BYTE) || (entry.op == OP_READ_BYTE))
							? BYTE_BITS : 4'd1;
						shift_d = entry.load_data;
					end
				end
			end
			PH_RST_LOW: begin
				tick_d = tick_inc;
				if (tick_x >= clamp(CW'(cfg.reset_low_time))) begin
					drive_d = 1'b0;
					phase_d = PH_RST_WAIT;
					tick_d  = '0;
				end
			end
			PH_RST_WAIT: begin
				tick_d = tick_inc;
				if (tick_x >= clamp(CW'(cfg.presence_sample_delay))) begin
					pres_d  = !entry.line;
					phase_d = PH_RST_REC;
					tick_d  = '0;
				end
			end
			PH_RST_REC: begin
				tick_d = tick_inc;
				if (tick_x >= clamp(CW'(cfg.reset_recovery_time))) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
					done    = 1'b1;
				end
			end
			PH_SLOT: begin
				tick_d = tick_inc;
				if (is_read(kind_q)) begin
					low = clamp(CW'(cfg.read_low_time));
				end else if (shift_q[0]) begin
					low = clamp(CW'(cfg.write_one_low_time));
				end else begin
					low = clamp(CW'(cfg.write_zero_low_time));
				end
				endv = clamp(CW'(cfg.slot_time));
				if (endv < low) begin
					endv = low;
				end
				if (tick_x >= low) begin
					drive_d = 1'b0;
				end
				// read sample, pulled in to the slot end when that comes first
				if (is_read(kind_q)) begin
					sp = clamp(CW'(cfg.read_sample_time));
					if (sp == '0) begin
						sp = CW'(1);
					end
					if ((sp > endv) && (endv != '0)) begin
						sp = endv;
					end
					if (tick_x == sp) begin
						total   = (kind_q == OP_READ_BYTE) ? BYTE_BITS : 4'd1;
						idx     = 3'(total - bits_q);
						shift_d = shift_q | (8'(entry.line) << idx);
					end
				end
				// slot end: next bit or finish
				if (tick_x >= endv) begin
					if (!is_read(kind_q)) begin
						shift_d = shift_q >> 1;
					end
					bits_d = bits_q - 4'd1;
					tick_d = '0;
					if (bits_d == 4'd0) begin
						phase_d = PH_IDLE;
						drive_d = 1'b0;
						done    = 1'b1;
					end else begin
						drive_d = 1'b1;
					end
				end
			end
			default: begin
				tick_d  = tick_inc;
				phase_d = PH_IDLE;
				drive_d = 1'b0;
			end
		endcase

		res.drive_low        = drive_d;
		res.busy_res         = (phase_d != PH_IDLE);
		res.done_res         = done;
		res.presence_found   = pres_d;
		res.read_value       = is_read(kind_d) ? shift_d : 8'd0;
		res.command_rejected = clamp_unused_guard(rej);
	end

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else if (entry_pop) begin
			phase_q <= phase_d;
		end
	end

	// sequencer datapath state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q  <= '0;
			tick_q  <= '0;
			bits_q  <= '0;
			shift_q <= '0;
			pres_q  <= 1'b0;
			drive_q <= 1'b0;
		end else if (entry_pop) begin
			kind_q  <= kind_d;
			tick_q  <= tick_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			pres_q  <= pres_d;
			drive_q <= drive_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (entry_pop) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (entry_pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

`default_nettype wire

/* rtl/one_wire_bus_master_unit.sv */
// channel   | direction | handshake             | payload
// ----------+-----------+-----------------------+-----------------------
// input     | in        | in_valid / in_ready   | in_item (owbm_in_t)
// result    | out       | out_valid / out_ready | out_item (owbm_out_t)
// config    | in        | cfg_we                | cfg_index, cfg_data
//
// one request per clock while in_ready is high: each request is one bus tick,
// and the sequencer takes one tick per cycle, unless the result is stalled, from
// a two-entry queue into the output register, where its result is held.
// reset puts the sequencer in idle with the line released and loads the
// default timings; a stalled result holds while the queue takes two more.
`default_nettype none

module one_wire_bus_master_unit
	import owbm_pkg::*;
#(
	parameter int BITS_PER_BYTE = BITS_PER_BYTE_DEF,
	parameter int TIMER_WIDTH   = TIMER_WIDTH_DEF
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	output logic                        in_ready,
	input  wire owbm_in_t               in_item,
	output logic                        out_valid,
	input  wire logic                   out_ready,
	output owbm_out_t                   out_item,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	owbm_cfg_t   cfg_q;
	logic        entry_valid;
	owbm_entry_t entry;
	logic        entry_pop;

	// timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (owbm_reg_t'(cfg_index))
				REG_RESET_LOW:  cfg_q.reset_low_time        <= cfg_data[W_RESET_LOW-1:0];
				REG_PRES_DELAY: cfg_q.presence_sample_delay <= cfg_data[W_PRES_DLY-1:0];
				REG_RESET_REC:  cfg_q.reset_recovery_time   <= cfg_data[W_RESET_REC-1:0];
				REG_SLOT:       cfg_q.slot_time             <= cfg_data[W_SLOT-1:0];
				REG_W1_LOW:     cfg_q.write_one_low_time    <= cfg_data[W_W1_LOW-1:0];
				REG_W0_LOW:     cfg_q.write_zero_low_time   <= cfg_data[W_W0_LOW-1:0];
				REG_RD_LOW:     cfg_q.read_low_time         <= cfg_data[W_RD_LOW-1:0];
				REG_RD_SAMPLE:  cfg_q.read_sample_time      <= cfg_data[W_RD_SAMPLE-1:0];
				default: ;
			endcase
		end
	end

	owbm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.entry_valid (entry_valid),
		.entry       (entry),
		.entry_pop   (entry_pop)
	);

	owbm_back #(
		.BITS_PER_BYTE (BITS_PER_BYTE),
		.TIMER_WIDTH   (TIMER_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.entry_valid (entry_valid),
		.entry       (entry),
		.entry_pop   (entry_pop),
		.cfg         (cfg_q),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

`default_nettype wire

/* rtl/owbm_checker.sv */
`default_nettype none

`include "one_wire_bus_master_unit_defines.svh"

module owbm_checker
	import owbm_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   in_ready,
	input  wire owbm_in_t               in_item,
	input  wire logic                   out_valid,
	input  wire logic                   out_ready,
	input  wire owbm_out_t              out_item,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

	// a finished command leaves the master idle
	`OWBM_ASSERT_NOW(a_done_idle, out_valid && out_item.done_res, !out_item.busy_res, "done while busy")

	// an idle master never holds the line low
	`OWBM_ASSERT_NOW(a_idle_released, out_valid && !out_item.busy_res, !out_item.drive_low, "idle drives low")

	// a refused request only happens during a running command
	`OWBM_ASSERT_NOW(a_reject_busy, out_valid && out_item.command_rejected, out_item.busy_res || out_item.done_res, "reject when idle")

	// a stalled result holds
	`OWBM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_item), "result dropped under stall")

endmodule

bind one_wire_bus_master_unit owbm_checker u_owbm_checker (.*);

`default_nettype wire
